// ----- rtl/i2c_master_transfer_sequencer_macros.svh -----
// ----------------------------------------------------------------------------
// I2C master transfer sequencer: assertion macros
// Shared property shapes for the sequencer's checker.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_MACROS_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_MACROS_SVH

// same-cycle implication, disabled in reset
`define I2CMTS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("i2cmts assertion failed");

// next-cycle implication, disabled in reset
`define I2CMTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("i2cmts assertion failed");

`endif

// ----- rtl/i2cmts_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C master transfer sequencer package
// Event codes, bus commands, status codes, phases and the result record.
// ----------------------------------------------------------------------------
package i2cmts_pkg;

   localparam int unsigned MAX_TRANSFER = 256;
   localparam int unsigned LEN_W        = 9;

   // controller events
   localparam logic [2:0] MODE_BEGIN    = 3'd0;
   localparam logic [2:0] MODE_TX_EMPTY = 3'd1;
   localparam logic [2:0] MODE_TX_END   = 3'd2;
   localparam logic [2:0] MODE_RX_FULL  = 3'd3;
   localparam logic [2:0] MODE_ERROR    = 3'd4;

   // bus commands
   localparam logic [1:0] CMD_NONE    = 2'd0;
   localparam logic [1:0] CMD_START   = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;
   localparam logic [1:0] CMD_STOP    = 2'd3;

   // clock-stretch wait control
   localparam logic [1:0] WAIT_KEEP  = 2'd0;
   localparam logic [1:0] WAIT_SET   = 2'd1;
   localparam logic [1:0] WAIT_CLEAR = 2'd2;

   // completion status
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_BUSY  = 2'd1;
   localparam logic [1:0] ST_IOERR = 2'd2;

   // interrupt enable bits
   localparam logic [4:0] EN_TX   = 5'b00001;
   localparam logic [4:0] EN_TEND = 5'b00010;
   localparam logic [4:0] EN_RX   = 5'b00100;
   localparam logic [4:0] EN_NACK = 5'b01000;
   localparam logic [4:0] EN_STOP = 5'b10000;

   // configuration register indexes
   localparam logic [1:0] CSR_ADDR = 2'd0;
   localparam logic [1:0] CSR_SEND = 2'd1;
   localparam logic [1:0] CSR_RECV = 2'd2;

   typedef enum logic [7:0] {
      PH_IDLE    = 8'b0000_0001,
      PH_START   = 8'b0000_0010,
      PH_SEND    = 8'b0000_0100,
      PH_RESTART = 8'b0000_1000,
      PH_STOP    = 8'b0001_0000,
      PH_RTOP    = 8'b0010_0000,
      PH_RECV    = 8'b0100_0000,
      PH_RLAST   = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic       drive_valid;
      logic [7:0] drive_byte;
      logic       take_send;
      logic [1:0] bus_command;
      logic [1:0] wait_control;
      logic       nack_next;
      logic       got_valid;
      logic [7:0] got_byte;
      logic [4:0] irq_enables;
      logic       clear_stop_flag;
      logic       finished;
      logic [1:0] result_status;
   } rsp_type;

   // saturate a requested length at the transfer limit
   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
      if (v > LEN_W'(MAX_TRANSFER)) begin
         return LEN_W'(MAX_TRANSFER);
      end
      return v;
   endfunction

endpackage

// ----- rtl/i2c_master_transfer_sequencer.sv -----
// ----------------------------------------------------------------------------
// I2C master transfer sequencer
// Steps one master write, read or write-restart-read transaction, one
// controller event per beat, and gives the controller actions for each event.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | beat carries
//  --------+-----------+--------------------+------------------------------------
//  req_    | in        | valid / stall      | one controller event and its bytes
//  rsp_    | out       | valid / stall      | one action record for that event
//  csr_    | in        | write enable only  | address, send length, recv length
//
//  Each event is captured in the input register, then stepped into the
//  result register; one event per cycle sustained while rsp_stall is low.
//  The step from input register to result register is combinational.
//  Synchronous active-high reset clears phase, counts, mask, configuration and valid flags.
//  A stalled result holds; the input register still empties into it as soon
//  as the result is taken, so a stall costs no extra bubble.
//
module i2c_master_transfer_sequencer (
   input  logic       clock,
   input  logic       reset,
   // event channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_mode,
   input  logic [7:0] req_send_byte,
   input  logic [7:0] req_line_byte,
   input  logic       req_stop_seen,
   input  logic       req_bus_busy,
   // action channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_drive_valid,
   output logic [7:0] rsp_drive_byte,
   output logic       rsp_take_send,
   output logic [1:0] rsp_bus_command,
   output logic [1:0] rsp_wait_control,
   output logic       rsp_nack_next,
   output logic       rsp_got_valid,
   output logic [7:0] rsp_got_byte,
   output logic [4:0] rsp_irq_enables,
   output logic       rsp_clear_stop_flag,
   output logic       rsp_finished,
   output logic [1:0] rsp_result_status,
   // configuration
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [8:0] csr_wdata
);

   localparam int unsigned LW = i2cmts_pkg::LEN_W;

   // configuration registers
   logic [6:0]    cfg_addr_ff;
   logic [LW-1:0] cfg_send_ff;
   logic [LW-1:0] cfg_recv_ff;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [2:0] in_mode_ff;
   logic [7:0] in_send_byte_ff;
   logic [7:0] in_line_byte_ff;
   logic       in_stop_seen_ff;
   logic       in_bus_busy_ff;

   // transaction state
   i2cmts_pkg::phase_type phase_ff, phase_in;
   logic [LW-1:0] send_left_ff, send_left_in;
   logic [LW-1:0] recv_left_ff, recv_left_in;
   logic [1:0]    error_code_ff, error_code_in;
   logic [4:0]    enable_bits_ff, enable_bits_in;
   logic [6:0]    addr_latch_ff, addr_latch_in;
   logic          waiting_ff, waiting_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   i2cmts_pkg::rsp_type rsp_ff, rsp_in;

   logic          load;
   logic          advance;
   logic [LW-1:0] send_dec;

   // An event moves to the result register when that register is empty or
   // being taken in this cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign load      = req_valid && !req_stall;

   assign in_valid_in  = load || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // ------------------------------------------------------------------
   // Configuration writes; an index past the list is dropped.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_addr_ff <= '0;
         cfg_send_ff <= '0;
         cfg_recv_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            i2cmts_pkg::CSR_ADDR: cfg_addr_ff <= csr_wdata[6:0];
            i2cmts_pkg::CSR_SEND: cfg_send_ff <= csr_wdata[LW-1:0];
            i2cmts_pkg::CSR_RECV: cfg_recv_ff <= csr_wdata[LW-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Step logic: one event against the current phase.
   // ------------------------------------------------------------------
   assign send_dec = (send_left_ff != '0) ? send_left_ff - LW'(1) : send_left_ff;

   always_comb begin
      phase_in       = phase_ff;
      send_left_in   = send_left_ff;
      recv_left_in   = recv_left_ff;
      error_code_in  = error_code_ff;
      enable_bits_in = enable_bits_ff;
      addr_latch_in  = addr_latch_ff;
      waiting_in     = waiting_ff;
      rsp_in         = '0;

      unique case (in_mode_ff)
         i2cmts_pkg::MODE_BEGIN: begin
            if (in_bus_busy_ff) begin
               // busy bus: report at once, no transaction
               error_code_in        = i2cmts_pkg::ST_BUSY;
               phase_in             = i2cmts_pkg::PH_IDLE;
               waiting_in           = 1'b0;
               rsp_in.finished      = 1'b1;
               rsp_in.result_status = i2cmts_pkg::ST_BUSY;
            end else begin
               // sample configuration and issue the start
               error_code_in      = i2cmts_pkg::ST_OK;
               addr_latch_in      = cfg_addr_ff;
               send_left_in       = i2cmts_pkg::clamp_len(cfg_send_ff);
               recv_left_in       = i2cmts_pkg::clamp_len(cfg_recv_ff);
               phase_in           = i2cmts_pkg::PH_START;
               waiting_in         = 1'b1;
               enable_bits_in     = i2cmts_pkg::EN_TX | i2cmts_pkg::EN_NACK;
               rsp_in.bus_command = i2cmts_pkg::CMD_START;
            end
         end

         i2cmts_pkg::MODE_TX_EMPTY: begin
            if (phase_ff == i2cmts_pkg::PH_START) begin
               // address byte: write direction if there is data to send
               rsp_in.drive_valid = 1'b1;
               if (send_left_ff != '0) begin
                  rsp_in.drive_byte = {addr_latch_ff, 1'b0};
                  phase_in          = i2cmts_pkg::PH_SEND;
               end else begin
                  rsp_in.drive_byte = {addr_latch_ff, 1'b1};
                  enable_bits_in    = (enable_bits_ff | i2cmts_pkg::EN_RX)
                                      & ~i2cmts_pkg::EN_TX;
                  phase_in          = i2cmts_pkg::PH_RTOP;
               end
            end else if (phase_ff == i2cmts_pkg::PH_SEND) begin
               send_left_in = send_dec;
               if (send_dec == '0) begin
                  phase_in       = (recv_left_ff == '0) ? i2cmts_pkg::PH_STOP
                                                        : i2cmts_pkg::PH_RESTART;
                  enable_bits_in = (enable_bits_ff | i2cmts_pkg::EN_TEND)
                                   & ~i2cmts_pkg::EN_TX;
               end
               rsp_in.drive_valid = 1'b1;
               rsp_in.drive_byte  = in_send_byte_ff;
               rsp_in.take_send   = 1'b1;
            end
         end

         i2cmts_pkg::MODE_TX_END: begin
            if (phase_ff == i2cmts_pkg::PH_STOP) begin
               enable_bits_in     = (enable_bits_ff & ~i2cmts_pkg::EN_TEND)
                                    | i2cmts_pkg::EN_STOP;
               rsp_in.bus_command = i2cmts_pkg::CMD_STOP;
            end else if (phase_ff == i2cmts_pkg::PH_RESTART) begin
               enable_bits_in     = i2cmts_pkg::EN_TX | i2cmts_pkg::EN_NACK;
               rsp_in.bus_command = i2cmts_pkg::CMD_RESTART;
               phase_in           = i2cmts_pkg::PH_START;
            end
         end

         i2cmts_pkg::MODE_RX_FULL: begin
            if (phase_ff == i2cmts_pkg::PH_RTOP) begin
               // dummy read of the address echo
               if (recv_left_ff <= LW'(2)) begin
                  rsp_in.wait_control = i2cmts_pkg::WAIT_SET;
               end
               if (recv_left_ff <= LW'(1)) begin
                  rsp_in.nack_next = 1'b1;
                  phase_in         = i2cmts_pkg::PH_RLAST;
               end else begin
                  phase_in = i2cmts_pkg::PH_RECV;
               end
            end else if (phase_ff == i2cmts_pkg::PH_RECV) begin
               if (recv_left_ff == LW'(3)) begin
                  rsp_in.wait_control = i2cmts_pkg::WAIT_SET;
               end
               if (recv_left_ff == LW'(2)) begin
                  rsp_in.nack_next = 1'b1;
                  phase_in         = i2cmts_pkg::PH_RLAST;
               end
               rsp_in.got_valid = 1'b1;
               rsp_in.got_byte  = in_line_byte_ff;
               if (recv_left_ff != '0) begin
                  recv_left_in = recv_left_ff - LW'(1);
               end
            end else if (phase_ff == i2cmts_pkg::PH_RLAST) begin
               // final byte: release the wait and stop
               rsp_in.clear_stop_flag = 1'b1;
               enable_bits_in         = (enable_bits_ff | i2cmts_pkg::EN_STOP)
                                        & ~i2cmts_pkg::EN_RX;
               rsp_in.bus_command     = i2cmts_pkg::CMD_STOP;
               rsp_in.got_valid       = 1'b1;
               rsp_in.got_byte        = in_line_byte_ff;
               rsp_in.wait_control    = i2cmts_pkg::WAIT_CLEAR;
               if (recv_left_ff != '0) begin
                  recv_left_in = recv_left_ff - LW'(1);
               end
               phase_in = i2cmts_pkg::PH_STOP;
            end
         end

         i2cmts_pkg::MODE_ERROR: begin
            if (in_stop_seen_ff) begin
               // stop on the bus: close the transaction
               if (phase_ff != i2cmts_pkg::PH_STOP) begin
                  error_code_in = i2cmts_pkg::ST_IOERR;
               end
               enable_bits_in = '0;
               if (waiting_ff) begin
                  waiting_in             = 1'b0;
                  rsp_in.finished        = 1'b1;
                  rsp_in.result_status   = (phase_ff != i2cmts_pkg::PH_STOP)
                                           ? i2cmts_pkg::ST_IOERR : error_code_ff;
                  rsp_in.clear_stop_flag = 1'b1;
               end
               phase_in = i2cmts_pkg::PH_IDLE;
            end else begin
               // NACK or other fault: force a stop
               error_code_in          = i2cmts_pkg::ST_IOERR;
               phase_in               = i2cmts_pkg::PH_STOP;
               rsp_in.clear_stop_flag = 1'b1;
               enable_bits_in         = i2cmts_pkg::EN_STOP;
               rsp_in.bus_command     = i2cmts_pkg::CMD_STOP;
            end
         end

         default: ;
      endcase

      rsp_in.irq_enables = enable_bits_in;
   end

   // ------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         phase_ff       <= i2cmts_pkg::PH_IDLE;
         send_left_ff   <= '0;
         recv_left_ff   <= '0;
         error_code_ff  <= i2cmts_pkg::ST_OK;
         enable_bits_ff <= '0;
         addr_latch_ff  <= '0;
         waiting_ff     <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            phase_ff       <= phase_in;
            send_left_ff   <= send_left_in;
            recv_left_ff   <= recv_left_in;
            error_code_ff  <= error_code_in;
            enable_bits_ff <= enable_bits_in;
            addr_latch_ff  <= addr_latch_in;
            waiting_ff     <= waiting_in;
         end
      end
   end

   // ------------------------------------------------------------------
   // Payload registers: input captures on load, result on advance; hold otherwise.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (load) begin
         in_mode_ff      <= req_mode;
         in_send_byte_ff <= req_send_byte;
         in_line_byte_ff <= req_line_byte;
         in_stop_seen_ff <= req_stop_seen;
         in_bus_busy_ff  <= req_bus_busy;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_drive_valid     = rsp_ff.drive_valid;
   assign rsp_drive_byte      = rsp_ff.drive_byte;
   assign rsp_take_send       = rsp_ff.take_send;
   assign rsp_bus_command     = rsp_ff.bus_command;
   assign rsp_wait_control    = rsp_ff.wait_control;
   assign rsp_nack_next       = rsp_ff.nack_next;
   assign rsp_got_valid       = rsp_ff.got_valid;
   assign rsp_got_byte        = rsp_ff.got_byte;
   assign rsp_irq_enables     = rsp_ff.irq_enables;
   assign rsp_clear_stop_flag = rsp_ff.clear_stop_flag;
   assign rsp_finished        = rsp_ff.finished;
   assign rsp_result_status   = rsp_ff.result_status;

endmodule

// ----- rtl/i2cmts_checker.sv -----
// ----------------------------------------------------------------------------
// I2C master transfer sequencer checker
// Port-level properties of the sequencer, bound into the sequencer module.
// ----------------------------------------------------------------------------
`include "i2c_master_transfer_sequencer_macros.svh"

module i2cmts_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_drive_valid,
   input logic [7:0] rsp_drive_byte,
   input logic       rsp_take_send,
   input logic       rsp_got_valid,
   input logic [7:0] rsp_got_byte,
   input logic       rsp_finished,
   input logic [1:0] rsp_result_status
);

   // status only means something on completion
   `I2CMTS_ASSERT_IMPLY(a_status_only_on_finish, clock, reset, rsp_valid && !rsp_finished, rsp_result_status == i2cmts_pkg::ST_OK)

   // a consumed send byte is always driven out
   `I2CMTS_ASSERT_IMPLY(a_take_drives, clock, reset, rsp_valid && rsp_take_send, rsp_drive_valid)

   // unqualified bytes read as zero
   `I2CMTS_ASSERT_IMPLY(a_idle_bytes_zero, clock, reset, rsp_valid && !rsp_drive_valid && !rsp_got_valid, rsp_drive_byte == 8'd0 && rsp_got_byte == 8'd0)

   // a stalled result holds
   `I2CMTS_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_drive_byte) && $stable(rsp_got_byte))

endmodule

bind i2c_master_transfer_sequencer i2cmts_checker u_i2cmts_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_drive_valid   (rsp_drive_valid),
   .rsp_drive_byte    (rsp_drive_byte),
   .rsp_take_send     (rsp_take_send),
   .rsp_got_valid     (rsp_got_valid),
   .rsp_got_byte      (rsp_got_byte),
   .rsp_finished      (rsp_finished),
   .rsp_result_status (rsp_result_status)
);
